/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every clock edge out of reset
`define CIST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// antecedent implies the property at the same edge
`define CIST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define CIST_ASSERT(lbl, clk, rstn, prop)
`define CIST_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif

`endif

/* hw/rtl/cist_pkg.sv */
// ----------------------------------------------------------------------------
// cist_pkg
// Shared types, constants and the t-factor table for the CI stop test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cist_pkg;

  localparam int unsigned STATION_COUNT = 3;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned SQ_W    = 64;
  localparam int unsigned ROOT_W  = 32;
  localparam int unsigned T_W     = 11;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned LIM_W   = 16;
  localparam int unsigned LIM_FRAC = 16;

  localparam logic [STAT_W-1:0] STATUS_OK  = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_FEW = 3'd4;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 16'd3277;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2^43
  localparam int unsigned RECIP_SHIFT = 50;
  localparam int unsigned RECIP_HALF  = 22;
  localparam logic [43:0] RECIP_100 =
    44'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);

  // 0.975 Student-t quantiles, in hundredths
  localparam logic [T_W-1:0] T_TABLE [35] = '{
    11'd1271, 11'd430, 11'd318, 11'd278, 11'd257, 11'd245, 11'd236, 11'd231,
    11'd226,  11'd223, 11'd220, 11'd218, 11'd216, 11'd214, 11'd213, 11'd212,
    11'd211,  11'd210, 11'd209, 11'd209, 11'd208, 11'd207, 11'd207, 11'd206,
    11'd206,  11'd206, 11'd205, 11'd205, 11'd204, 11'd204, 11'd202, 11'd201,
    11'd200,  11'd198, 11'd196
  };

  // per-station result handed from a lane to the output stage
  typedef struct packed {
    logic              vld;
    logic [CNT_W-1:0]  n;
    logic [SUM_W-1:0]  mean;
    logic [SUM_W-1:0]  hw;
    logic [SQ_W-1:0]   lim_mean;
  } cist_lane_res_t;

  function automatic logic [T_W-1:0] t_factor(input logic [CNT_W-1:0] dof);
    logic [CNT_W-1:0] idx;
    logic [T_W-1:0]   t;
    idx = dof - 16'd1;
    if (dof >= 16'd1 && dof <= 16'd30) begin
      t = T_TABLE[idx[5:0]];
    end else if (dof <= 16'd40) begin
      t = T_TABLE[30];
    end else if (dof <= 16'd50) begin
      t = T_TABLE[31];
    end else if (dof <= 16'd60) begin
      t = T_TABLE[32];
    end else if (dof <= 16'd120) begin
      t = T_TABLE[33];
    end else begin
      t = T_TABLE[34];
    end
    return t;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cist_div.sv */
// ----------------------------------------------------------------------------
// cist_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cist_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 16,
  parameter int unsigned PW = 80
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [PW-1:0] pay_i,
  output logic               vld_o,
  output logic [NW-1:0]      quo_o,
  output logic [PW-1:0]      pay_o
);

  logic [NW-1:0] vld_q;
  logic [NW-1:0] num_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [PW-1:0] pay_q [NW];

  logic [NW-1:0] num_d [NW];
  logic [DW-1:0] rem_d [NW];
  logic [DW-1:0] den_d [NW];
  logic [PW-1:0] pay_d [NW];

  // each stage shifts in one dividend bit and tries one subtract
  always_comb begin
    logic [NW-1:0] num_s;
    logic [DW-1:0] rem_s;
    logic [DW-1:0] den_s;
    logic [PW-1:0] pay_s;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    for (int s = 0; s < NW; s++) begin
      if (s == 0) begin
        num_s = num_i;
        rem_s = '0;
        den_s = den_i;
        pay_s = pay_i;
      end else begin
        num_s = num_q[s-1];
        rem_s = rem_q[s-1];
        den_s = den_q[s-1];
        pay_s = pay_q[s-1];
      end
      trial    = {rem_s, num_s[NW-1]};
      diff     = trial - {1'b0, den_s};
      ge       = (trial >= {1'b0, den_s});
      rem_d[s] = ge ? diff[DW-1:0] : trial[DW-1:0];
      num_d[s] = {num_s[NW-2:0], ge};
      den_d[s] = den_s;
      pay_d[s] = pay_s;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NW-2:0], vld_i};
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      rem_q <= rem_d;
      den_q <= den_d;
      pay_q <= pay_d;
    end
  end

  assign vld_o = vld_q[NW-1];
  assign quo_o = num_q[NW-1];
  assign pay_o = pay_q[NW-1];

endmodule

`default_nettype wire

/* hw/rtl/cist_sqrt.sv */
// ----------------------------------------------------------------------------
// cist_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cist_sqrt #(
  parameter int unsigned RW = 32,
  parameter int unsigned PW = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            vld_i,
  input  wire logic [2*RW-1:0] rad_i,
  input  wire logic [PW-1:0]   pay_i,
  output logic                 vld_o,
  output logic [RW-1:0]        root_o,
  output logic [PW-1:0]        pay_o
);

  logic [RW-1:0]   vld_q;
  logic [2*RW-1:0] rad_q  [RW];
  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [PW-1:0]   pay_q  [RW];

  logic [2*RW-1:0] rad_d  [RW];
  logic [RW+1:0]   rem_d  [RW];
  logic [RW-1:0]   root_d [RW];
  logic [PW-1:0]   pay_d  [RW];

  // each stage brings down two radicand bits and tries 4*root+1
  always_comb begin
    logic [2*RW-1:0] rad_s;
    logic [RW+1:0]   rem_s;
    logic [RW-1:0]   root_s;
    logic [PW-1:0]   pay_s;
    logic [RW+3:0]   wide;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            ge;
    for (int s = 0; s < RW; s++) begin
      if (s == 0) begin
        rad_s  = rad_i;
        rem_s  = '0;
        root_s = '0;
        pay_s  = pay_i;
      end else begin
        rad_s  = rad_q[s-1];
        rem_s  = rem_q[s-1];
        root_s = root_q[s-1];
        pay_s  = pay_q[s-1];
      end
      wide      = {rem_s, rad_s[2*RW-1 -: 2]};
      trial     = {2'b00, root_s, 2'b01};
      diff      = wide - trial;
      ge        = (wide >= trial);
      rem_d[s]  = ge ? diff[RW+1:0] : wide[RW+1:0];
      root_d[s] = {root_s[RW-2:0], ge};
      rad_d[s]  = {rad_s[2*RW-3:0], 2'b00};
      pay_d[s]  = pay_s;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RW-2:0], vld_i};
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      pay_q  <= pay_d;
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign pay_o  = pay_q[RW-1];

endmodule

`default_nettype wire

/* hw/rtl/cist_lane.sv */
// ----------------------------------------------------------------------------
// cist_lane
// One station: mean, variance, root, t scaling and the limit product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cist_lane
  import cist_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             vld_i,
  input  wire logic [CNT_W-1:0] n_i,
  input  wire logic [SUM_W-1:0] sum_i,
  input  wire logic [SQ_W-1:0]  sumsq_i,
  input  wire logic [LIM_W-1:0] limit_i,
  output cist_lane_res_t        res_o
);

  // ---- mean = sum / n ----
  logic                   vld_a;
  logic [SUM_W-1:0]       mean_a;
  logic [CNT_W+SQ_W-1:0]  pay_a;

  cist_div #(.NW(SUM_W), .DW(CNT_W), .PW(CNT_W + SQ_W)) u_div_mean (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en_i),
    .vld_i (vld_i),
    .num_i (sum_i),
    .den_i (n_i),
    .pay_i ({n_i, sumsq_i}),
    .vld_o (vld_a),
    .quo_o (mean_a),
    .pay_o (pay_a)
  );

  // ---- n*mean and n*(n-1) ----
  logic                 vld_b_q;
  logic [CNT_W-1:0]     n_b_q;
  logic [SUM_W-1:0]     mean_b_q, nm_b_q;
  logic [SQ_W-1:0]      sumsq_b_q;
  logic [2*CNT_W-1:0]   nn_b_q;
  logic [CNT_W-1:0]     n_a;
  logic [CNT_W+SUM_W-1:0] nm_full;
  logic [2*CNT_W-1:0]   nn_full;

  assign n_a     = pay_a[CNT_W+SQ_W-1:SQ_W];
  assign nm_full = n_a * mean_a;
  assign nn_full = n_a * (n_a - 16'd1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_b_q     <= n_a;
      mean_b_q  <= mean_a;
      sumsq_b_q <= pay_a[SQ_W-1:0];
      nm_b_q    <= nm_full[SUM_W-1:0];  // never exceeds the sum
      nn_b_q    <= nn_full;
    end
  end

  // ---- n*mean*mean as two 48x24 partial products ----
  logic                 vld_c_q;
  logic [CNT_W-1:0]     n_c_q;
  logic [SUM_W-1:0]     mean_c_q;
  logic [SQ_W-1:0]      sumsq_c_q;
  logic [2*CNT_W-1:0]   nn_c_q;
  logic [SUM_W+23:0]    p0_c_q, p1_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_c_q     <= n_b_q;
      mean_c_q  <= mean_b_q;
      sumsq_c_q <= sumsq_b_q;
      nn_c_q    <= nn_b_q;
      p0_c_q    <= nm_b_q * mean_b_q[23:0];
      p1_c_q    <= nm_b_q * mean_b_q[47:24];
    end
  end

  // ---- sum of partial products ----
  logic                 vld_d_q;
  logic [CNT_W-1:0]     n_d_q;
  logic [SUM_W-1:0]     mean_d_q;
  logic [SQ_W-1:0]      sumsq_d_q;
  logic [2*CNT_W-1:0]   nn_d_q;
  logic [95:0]          prod_d_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_d_q     <= n_c_q;
      mean_d_q  <= mean_c_q;
      sumsq_d_q <= sumsq_c_q;
      nn_d_q    <= nn_c_q;
      prod_d_q  <= {24'd0, p0_c_q} + {p1_c_q, 24'd0};
    end
  end

  // ---- clamp sumsq - n*mean^2 at zero ----
  logic                 vld_e_q;
  logic [CNT_W-1:0]     n_e_q;
  logic [SUM_W-1:0]     mean_e_q;
  logic [2*CNT_W-1:0]   nn_e_q;
  logic [SQ_W-1:0]      diff_e_q;
  logic                 neg_d;

  assign neg_d = (prod_d_q[95:64] != '0) || (prod_d_q[63:0] >= sumsq_d_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_e_q    <= n_d_q;
      mean_e_q <= mean_d_q;
      nn_e_q   <= nn_d_q;
      diff_e_q <= neg_d ? '0 : (sumsq_d_q - prod_d_q[63:0]);
    end
  end

  // valid bits of the short stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
    end else if (en_i) begin
      vld_b_q <= vld_a;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
      vld_e_q <= vld_d_q;
    end
  end

  // ---- var/n = diff / (n*(n-1)) ----
  logic                     vld_f;
  logic [SQ_W-1:0]          q_f;
  logic [CNT_W+SUM_W-1:0]   pay_f;

  cist_div #(.NW(SQ_W), .DW(2*CNT_W), .PW(CNT_W + SUM_W)) u_div_var (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en_i),
    .vld_i (vld_e_q),
    .num_i (diff_e_q),
    .den_i (nn_e_q),
    .pay_i ({n_e_q, mean_e_q}),
    .vld_o (vld_f),
    .quo_o (q_f),
    .pay_o (pay_f)
  );

  // ---- root ----
  logic                     vld_g;
  logic [ROOT_W-1:0]        s_g;
  logic [CNT_W+SUM_W-1:0]   pay_g;

  cist_sqrt #(.RW(ROOT_W), .PW(CNT_W + SUM_W)) u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en_i),
    .vld_i (vld_f),
    .rad_i (q_f),
    .pay_i (pay_f),
    .vld_o (vld_g),
    .root_o(s_g),
    .pay_o (pay_g)
  );

  // ---- s*t and limit*mean ----
  logic                 vld_h_q;
  logic [CNT_W-1:0]     n_h_q;
  logic [SUM_W-1:0]     mean_h_q;
  logic [ROOT_W+T_W-1:0] x_h_q;
  logic [SQ_W-1:0]      lm_h_q;
  logic [CNT_W-1:0]     n_g;
  logic [SUM_W-1:0]     mean_g;

  assign n_g    = pay_g[CNT_W+SUM_W-1:SUM_W];
  assign mean_g = pay_g[SUM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_h_q    <= n_g;
      mean_h_q <= mean_g;
      x_h_q    <= s_g * t_factor(n_g - 16'd1);
      lm_h_q   <= limit_i * mean_g;
    end
  end

  // ---- divide by 100: reciprocal halves ----
  logic                 vld_i_q;
  logic [CNT_W-1:0]     n_i_q;
  logic [SUM_W-1:0]     mean_i_q;
  logic [SQ_W-1:0]      lm_i_q;
  logic [ROOT_W+T_W+RECIP_HALF-1:0] pl_i_q, ph_i_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_i_q    <= n_h_q;
      mean_i_q <= mean_h_q;
      lm_i_q   <= lm_h_q;
      pl_i_q   <= x_h_q * RECIP_100[RECIP_HALF-1:0];
      ph_i_q   <= x_h_q * RECIP_100[2*RECIP_HALF-1:RECIP_HALF];
    end
  end

  // ---- recombine and shift: half-width ----
  localparam int unsigned TOT_W = ROOT_W + T_W + 2 * RECIP_HALF;
  logic [TOT_W-1:0] tot_i;
  logic             vld_j_q;
  logic [CNT_W-1:0] n_j_q;
  logic [SUM_W-1:0] mean_j_q;
  logic [SUM_W-1:0] hw_j_q;
  logic [SQ_W-1:0]  lm_j_q;

  assign tot_i = {ph_i_q, {RECIP_HALF{1'b0}}} + {{RECIP_HALF{1'b0}}, pl_i_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_h_q <= 1'b0;
      vld_i_q <= 1'b0;
      vld_j_q <= 1'b0;
    end else if (en_i) begin
      vld_h_q <= vld_g;
      vld_i_q <= vld_h_q;
      vld_j_q <= vld_i_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_j_q    <= n_i_q;
      mean_j_q <= mean_i_q;
      lm_j_q   <= lm_i_q;
      hw_j_q   <= SUM_W'(tot_i[TOT_W-1:RECIP_SHIFT]);
    end
  end

  assign res_o = '{vld: vld_j_q, n: n_j_q, mean: mean_j_q, hw: hw_j_q, lim_mean: lm_j_q};

endmodule

`default_nettype wire

/* hw/rtl/confidence_interval_stop_test_top.sv */
// Throughput: one word per cycle; the whole datapath is pipelined, with the
// 48-stage mean divider, 64-stage variance divider and 32-stage root as the
// bulk of the depth. A held output stalls every stage together.
// Reset: valid bits clear, the limit register returns to 3277.
// ----------------------------------------------------------------------------
// confidence_interval_stop_test_top
// 95 percent Student-t interval stop test over three stations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module confidence_interval_stop_test_top
  import cist_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              cfg_we_i,
  input  wire logic [LIM_W-1:0]  cfg_wdata_i,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [CNT_W-1:0]  replications_i,
  input  wire logic [SUM_W-1:0]  sum_time_station1_i,
  input  wire logic [SUM_W-1:0]  sum_time_station2_i,
  input  wire logic [SUM_W-1:0]  sum_time_station3_i,
  input  wire logic [SQ_W-1:0]   sum_squares_station1_i,
  input  wire logic [SQ_W-1:0]   sum_squares_station2_i,
  input  wire logic [SQ_W-1:0]   sum_squares_station3_i,
  // output channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [STAT_W-1:0]      status_o,
  output logic [SUM_W-1:0]       mean_station1_o,
  output logic [SUM_W-1:0]       mean_station2_o,
  output logic [SUM_W-1:0]       mean_station3_o,
  output logic [SUM_W-1:0]       halfwidth_station1_o,
  output logic [SUM_W-1:0]       halfwidth_station2_o,
  output logic [SUM_W-1:0]       halfwidth_station3_o
);

  // relative error limit register
  logic [LIM_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // whole pipeline moves unless the output word is held
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  logic [SUM_W-1:0] sum_a   [STATION_COUNT];
  logic [SQ_W-1:0]  sumsq_a [STATION_COUNT];

  assign sum_a[0]   = sum_time_station1_i;
  assign sum_a[1]   = sum_time_station2_i;
  assign sum_a[2]   = sum_time_station3_i;
  assign sumsq_a[0] = sum_squares_station1_i;
  assign sumsq_a[1] = sum_squares_station2_i;
  assign sumsq_a[2] = sum_squares_station3_i;

  cist_lane_res_t           res [STATION_COUNT];
  logic [STATION_COUNT-1:0] lane_vld;
  logic [STATION_COUNT-1:0] over;

  for (genvar k = 0; k < STATION_COUNT; k++) begin : g_lane
    cist_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (in_valid_i),
      .n_i    (replications_i),
      .sum_i  (sum_a[k]),
      .sumsq_i(sumsq_a[k]),
      .limit_i(limit_q),
      .res_o  (res[k])
    );
    assign lane_vld[k] = res[k].vld;
    // half-width scaled to the limit's fraction bits against limit*mean
    assign over[k] = ({res[k].hw, {LIM_FRAC{1'b0}}} > res[k].lim_mean);
  end

  // status: first station over the limit, or too few replications
  logic [STAT_W-1:0] status_d;
  logic              few;

  assign few = (res[0].n < 16'd2);

  always_comb begin
    status_d = STATUS_OK;
    for (int k = STATION_COUNT - 1; k >= 0; k--) begin
      if (over[k]) begin
        status_d = STAT_W'(k + 1);
      end
    end
    if (few) begin
      status_d = STATUS_FEW;
    end
  end

  // output register
  logic              out_vld_q;
  logic [STAT_W-1:0] status_q;
  logic [SUM_W-1:0]  mean_q [STATION_COUNT];
  logic [SUM_W-1:0]  hw_q   [STATION_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= lane_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= status_d;
      for (int k = 0; k < STATION_COUNT; k++) begin
        mean_q[k] <= few ? '0 : res[k].mean;
        hw_q[k]   <= few ? '0 : res[k].hw;
      end
    end
  end

  assign out_valid_o          = out_vld_q;
  assign status_o             = status_q;
  assign mean_station1_o      = mean_q[0];
  assign mean_station2_o      = mean_q[1];
  assign mean_station3_o      = mean_q[2];
  assign halfwidth_station1_o = hw_q[0];
  assign halfwidth_station2_o = hw_q[1];
  assign halfwidth_station3_o = hw_q[2];

  // helpers for the checks below
  logic mean_any, hw_any, few_out, fail_out;

  assign mean_any = |{mean_station1_o, mean_station2_o, mean_station3_o};
  assign hw_any   = |{halfwidth_station1_o, halfwidth_station2_o, halfwidth_station3_o};
  assign few_out  = out_valid_o && (status_o == STATUS_FEW);
  assign fail_out = out_valid_o && (status_o != STATUS_OK) && (status_o != STATUS_FEW);

  // lanes run in lock step
  `CIST_ASSERT(a_lane_sync, clk_i, rst_ni, (lane_vld == '0) || (lane_vld == '1))
  // too few replications leaves every mean and half-width zero
  `CIST_ASSERT_IMP(a_few_zero, clk_i, rst_ni, few_out, !(mean_any || hw_any))
  // a failing station always has a nonzero half-width somewhere
  `CIST_ASSERT_IMP(a_fail_hw, clk_i, rst_ni, fail_out, hw_any)

endmodule

`default_nettype wire
